// ----- rtl/jpp_pkg.sv -----
// jpp_pkg: types, character codes and the microcode table of the json pretty printer
// no dependencies; used by jpp_decode and json_pretty_printer
`default_nettype none

package jpp_pkg;

	localparam int LevelW = 6;
	localparam int PcW    = 7;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_FOUR   = 8'h34;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_M      = 8'h6d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_ESC    = 8'h1b;

	// program entry points
	localparam logic [PcW-1:0] PC_DROP  = 7'd0;
	localparam logic [PcW-1:0] PC_PLAIN = 7'd1;
	localparam logic [PcW-1:0] PC_SCLOS = 7'd3;
	localparam logic [PcW-1:0] PC_OPEN  = 7'd10;
	localparam logic [PcW-1:0] PC_CLOSE = 7'd24;
	localparam logic [PcW-1:0] PC_COLON = 7'd38;
	localparam logic [PcW-1:0] PC_SOPEN = 7'd51;
	localparam logic [PcW-1:0] PC_EOT   = 7'd58;

	typedef enum logic [1:0] {
		OP_END,
		OP_IN,
		OP_LIT,
		OP_TABS
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       color;
		logic [7:0] lit;
	} ucode_t;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic              in_str;
		logic              esc;
	} state_t;

	function automatic ucode_t ucode(input logic [PcW-1:0] pc);
		ucode_t w;
		w = '{op: OP_END, color: 1'b0, lit: 8'h00};
		case (pc)
			// plain byte
			7'd1:  w = '{OP_IN,   1'b0, 8'h00};
			7'd2:  w = '{OP_END,  1'b0, 8'h00};
			// closing quote, then blue
			7'd3:  w = '{OP_IN,   1'b0, 8'h00};
			7'd4:  w = '{OP_LIT,  1'b1, CH_ESC};
			7'd5:  w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd6:  w = '{OP_LIT,  1'b1, CH_THREE};
			7'd7:  w = '{OP_LIT,  1'b1, CH_FOUR};
			7'd8:  w = '{OP_LIT,  1'b1, CH_M};
			7'd9:  w = '{OP_END,  1'b0, 8'h00};
			// opening brace or bracket, comma
			7'd10: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd11: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd12: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd13: w = '{OP_LIT,  1'b1, CH_TWO};
			7'd14: w = '{OP_LIT,  1'b1, CH_M};
			7'd15: w = '{OP_IN,   1'b0, 8'h00};
			7'd16: w = '{OP_LIT,  1'b0, CH_NL};
			7'd17: w = '{OP_TABS, 1'b0, CH_TAB};
			7'd18: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd19: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd20: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd21: w = '{OP_LIT,  1'b1, CH_FOUR};
			7'd22: w = '{OP_LIT,  1'b1, CH_M};
			7'd23: w = '{OP_END,  1'b0, 8'h00};
			// closing brace or bracket
			7'd24: w = '{OP_LIT,  1'b0, CH_NL};
			7'd25: w = '{OP_TABS, 1'b0, CH_TAB};
			7'd26: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd27: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd28: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd29: w = '{OP_LIT,  1'b1, CH_TWO};
			7'd30: w = '{OP_LIT,  1'b1, CH_M};
			7'd31: w = '{OP_IN,   1'b0, 8'h00};
			7'd32: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd33: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd34: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd35: w = '{OP_LIT,  1'b1, CH_FOUR};
			7'd36: w = '{OP_LIT,  1'b1, CH_M};
			7'd37: w = '{OP_END,  1'b0, 8'h00};
			// colon
			7'd38: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd39: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd40: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd41: w = '{OP_LIT,  1'b1, CH_TWO};
			7'd42: w = '{OP_LIT,  1'b1, CH_M};
			7'd43: w = '{OP_IN,   1'b0, 8'h00};
			7'd44: w = '{OP_LIT,  1'b0, CH_SPACE};
			7'd45: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd46: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd47: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd48: w = '{OP_LIT,  1'b1, CH_FOUR};
			7'd49: w = '{OP_LIT,  1'b1, CH_M};
			7'd50: w = '{OP_END,  1'b0, 8'h00};
			// opening quote
			7'd51: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd52: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd53: w = '{OP_LIT,  1'b1, CH_THREE};
			7'd54: w = '{OP_LIT,  1'b1, CH_ONE};
			7'd55: w = '{OP_LIT,  1'b1, CH_M};
			7'd56: w = '{OP_IN,   1'b0, 8'h00};
			7'd57: w = '{OP_END,  1'b0, 8'h00};
			// end of text
			7'd58: w = '{OP_LIT,  1'b1, CH_ESC};
			7'd59: w = '{OP_LIT,  1'b1, CH_LBRACK};
			7'd60: w = '{OP_LIT,  1'b1, CH_ZERO};
			7'd61: w = '{OP_LIT,  1'b1, CH_M};
			7'd62: w = '{OP_LIT,  1'b0, CH_NL};
			7'd63: w = '{OP_TABS, 1'b0, CH_TAB};
			7'd64: w = '{OP_END,  1'b0, 8'h00};
			default: w = '{OP_END, 1'b0, 8'h00};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/jpp_ifs.sv -----
// jpp_ifs: valid/ready channel interfaces for the json pretty printer
// no dependencies
`default_nettype none

interface jpp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jpp_pretty_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/jpp_decode.sv -----
// jpp_decode: classifies one input byte, picks the microcode entry and the next state
// depends on jpp_pkg
`default_nettype none

module jpp_decode #(
	parameter int MAX_DEPTH = 32
) (
	input  wire logic [7:0]           text_byte,
	input  wire logic                 end_of_text,
	input  wire jpp_pkg::state_t      cur,
	output jpp_pkg::state_t           nxt,
	output logic [jpp_pkg::PcW-1:0]   entry,
	output logic [jpp_pkg::LevelW-1:0] tabs
);

	localparam logic [jpp_pkg::LevelW-1:0] MaxLvl = jpp_pkg::LevelW'(MAX_DEPTH);

	always_comb begin
		nxt   = cur;
		entry = jpp_pkg::PC_PLAIN;
		if (end_of_text) begin
			entry = jpp_pkg::PC_EOT;
			nxt   = '0;
		end else if (cur.in_str) begin
			if (cur.esc) begin
				nxt.esc = 1'b0;
			end else if (text_byte == jpp_pkg::CH_BSLASH) begin
				nxt.esc = 1'b1;
			end else if (text_byte == jpp_pkg::CH_QUOTE) begin
				nxt.in_str = 1'b0;
				entry      = jpp_pkg::PC_SCLOS;
			end
		end else begin
			case (text_byte)
				jpp_pkg::CH_SPACE, jpp_pkg::CH_TAB, jpp_pkg::CH_NL: begin
					entry = jpp_pkg::PC_DROP;
				end
				jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACK: begin
					if (cur.level < MaxLvl)
						nxt.level = cur.level + 1'b1;
					entry = jpp_pkg::PC_OPEN;
				end
				jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACK: begin
					if (cur.level != '0)
						nxt.level = cur.level - 1'b1;
					entry = jpp_pkg::PC_CLOSE;
				end
				jpp_pkg::CH_COMMA: begin
					entry = jpp_pkg::PC_OPEN;
				end
				jpp_pkg::CH_COLON: begin
					entry = jpp_pkg::PC_COLON;
				end
				jpp_pkg::CH_QUOTE: begin
					nxt.in_str = 1'b1;
					nxt.esc    = 1'b0;
					entry      = jpp_pkg::PC_SOPEN;
				end
				default: begin
					entry = jpp_pkg::PC_PLAIN;
				end
			endcase
		end
		// end of text indents at the level it ends
		tabs = end_of_text ? cur.level : nxt.level;
	end

endmodule

`default_nettype wire

// ----- rtl/json_pretty_printer.sv -----
// Pretty printer for JSON text. Each input transaction starts a short microcode
// program that emits at most one byte per step. Color steps are stepped through
// even when colors are off, the tab step emits one tab per level, and a new item
// is taken only after the program of the last one has reached its end step. The
// output register stalls the program only while its byte is not taken.
// depends on jpp_pkg, jpp_ifs, jpp_decode
`default_nettype none

module json_pretty_printer #(
	parameter int MAX_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	jpp_text_if.sink        text,
	jpp_pretty_if.source    pretty,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data
);

	jpp_pkg::state_t                st_q;
	jpp_pkg::state_t                st_nxt;
	logic [jpp_pkg::PcW-1:0]        entry;
	logic [jpp_pkg::LevelW-1:0]     tabs_nxt;
	logic [jpp_pkg::LevelW-1:0]     tabs_q;
	logic [jpp_pkg::LevelW-1:0]     cnt_q;
	logic [jpp_pkg::PcW-1:0]        pc_q;
	logic [7:0]                     byte_q;
	logic                           busy_q;
	logic                           color_q;
	logic                           hold_v_q;
	logic [7:0]                     hold_q;
	logic                           out_v_q;
	logic [7:0]                     out_byte_q;
	logic                           out_last_q;

	jpp_pkg::ucode_t                uw;
	logic                           emit;
	logic [7:0]                     emit_byte;
	logic                           is_end;
	logic                           push;
	logic                           adv;
	logic                           accept;

	jpp_decode #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_decode (
		.text_byte  (text.text_byte),
		.end_of_text(text.end_of_text),
		.cur        (st_q),
		.nxt        (st_nxt),
		.entry      (entry),
		.tabs       (tabs_nxt)
	);

	assign text.ready         = !busy_q;
	assign accept             = text.valid && !busy_q;
	assign pretty.valid       = out_v_q;
	assign pretty.out_byte    = out_byte_q;
	assign pretty.last_of_run = out_last_q;

	always_comb begin
		uw        = jpp_pkg::ucode(pc_q);
		is_end    = (uw.op == jpp_pkg::OP_END);
		emit      = 1'b0;
		emit_byte = uw.lit;
		unique case (uw.op)
			jpp_pkg::OP_IN: begin
				emit      = 1'b1;
				emit_byte = byte_q;
			end
			jpp_pkg::OP_LIT: begin
				emit = !uw.color || color_q;
			end
			jpp_pkg::OP_TABS: begin
				emit = (cnt_q < tabs_q);
			end
			jpp_pkg::OP_END: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		// the held byte leaves when the next one arrives or the program ends
		push = busy_q && hold_v_q && (emit || is_end);
		adv  = busy_q && (!push || !out_v_q || pretty.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			busy_q   <= 1'b0;
			color_q  <= 1'b0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			pc_q     <= jpp_pkg::PC_DROP;
			cnt_q    <= '0;
			tabs_q   <= '0;
		end else begin
			if (cfg_wr_en)
				color_q <= cfg_wr_data;
			if (adv && push)
				out_v_q <= 1'b1;
			else if (out_v_q && pretty.ready)
				out_v_q <= 1'b0;
			if (accept) begin
				st_q   <= st_nxt;
				pc_q   <= entry;
				tabs_q <= tabs_nxt;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end
			if (adv) begin
				if (emit)
					hold_v_q <= 1'b1;
				else if (is_end)
					hold_v_q <= 1'b0;
				if (is_end) begin
					busy_q <= 1'b0;
				end else if (uw.op == jpp_pkg::OP_TABS && emit) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					pc_q  <= pc_q + 1'b1;
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_q <= text.text_byte;
		if (adv && emit)
			hold_q <= emit_byte;
		if (adv && push) begin
			out_byte_q <= hold_q;
			out_last_q <= is_end;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/jpp_checker.sv -----
// jpp_checker: port-level assertions for json_pretty_printer, bound to the top level
// depends on jpp_ifs through the top level's channel ports
`default_nettype none

module jpp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// output only appears while an item is in work
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output without an item in work");

	// a valid output carries known data
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({out_byte, out_last}))
		else $error("unknown output data");

endmodule

bind json_pretty_printer jpp_checker u_jpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (text.valid),
	.in_ready (text.ready),
	.out_valid(pretty.valid),
	.out_ready(pretty.ready),
	.out_byte (pretty.out_byte),
	.out_last (pretty.last_of_run)
);

`default_nettype wire

// ----- dv/json_pretty_printer_tb.sv -----
// json_pretty_printer_tb: self-checking testbench for the json pretty printer
// directed and random JSON text in, every formatted byte checked against a local predictor
// depends on jpp_pkg, jpp_ifs and json_pretty_printer
`default_nettype none

module json_pretty_printer_tb;

	localparam int MaxDepth    = 32;
	localparam int HoldCycles  = 300;
	localparam int StallLimit  = 2000;
	localparam int DrainCycles = 64;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} pretty_item_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	jpp_text_if   text_ch ();
	jpp_pretty_if pretty_ch ();

	json_pretty_printer #(
		.MAX_DEPTH(MaxDepth)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.pretty(pretty_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	text_item_t   json_q[$];
	pretty_item_t formatted_q[$];
	pretty_item_t want;

	// predictor state
	logic [5:0] nest_lvl    = '0;
	logic       in_string   = 1'b0;
	logic       esc_pending = 1'b0;
	logic       color_on    = 1'b0;

	logic text_taken   = 1'b0;
	int   idle_pct     = 34;
	int   hold_reqs    = 0;
	int   holds_done   = 0;
	int   hold_left    = 0;
	int   stall_cycles = 0;
	int   mismatches   = 0;
	int   text_items   = 0;
	bit   gen_obj_q[$];
	bit   gen_used_q[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic emit(input logic [7:0] b);
		formatted_q.push_back('{out_byte: b, last_of_run: 1'b0});
	endtask

	task automatic emit_color(input logic [7:0] digit);
		if (color_on) begin
			emit(jpp_pkg::CH_ESC);
			emit(jpp_pkg::CH_LBRACK);
			emit(jpp_pkg::CH_THREE);
			emit(digit);
			emit(jpp_pkg::CH_M);
		end
	endtask

	task automatic emit_newline();
		emit(jpp_pkg::CH_NL);
		for (int i = 0; i < nest_lvl; i++)
			emit(jpp_pkg::CH_TAB);
	endtask

	// expected output run for one accepted text transaction
	task automatic format_byte(input logic [7:0] b, input logic eot);
		int first;
		first = formatted_q.size();
		if (eot) begin
			if (color_on) begin
				emit(jpp_pkg::CH_ESC);
				emit(jpp_pkg::CH_LBRACK);
				emit(jpp_pkg::CH_ZERO);
				emit(jpp_pkg::CH_M);
			end
			emit_newline();
			nest_lvl = '0;
			in_string = 1'b0;
			esc_pending = 1'b0;
		end else if (in_string) begin
			if (esc_pending) begin
				esc_pending = 1'b0;
				emit(b);
			end else if (b == jpp_pkg::CH_BSLASH) begin
				esc_pending = 1'b1;
				emit(b);
			end else if (b == jpp_pkg::CH_QUOTE) begin
				in_string = 1'b0;
				emit(b);
				emit_color(jpp_pkg::CH_FOUR);
			end else begin
				emit(b);
			end
		end else if (b == jpp_pkg::CH_SPACE || b == jpp_pkg::CH_TAB || b == jpp_pkg::CH_NL) begin
		end else if (b == jpp_pkg::CH_LBRACE || b == jpp_pkg::CH_LBRACK) begin
			if (nest_lvl < MaxDepth)
				nest_lvl = nest_lvl + 1'b1;
			emit_color(jpp_pkg::CH_TWO);
			emit(b);
			emit_newline();
			emit_color(jpp_pkg::CH_FOUR);
		end else if (b == jpp_pkg::CH_RBRACE || b == jpp_pkg::CH_RBRACK) begin
			if (nest_lvl > 0)
				nest_lvl = nest_lvl - 1'b1;
			emit_newline();
			emit_color(jpp_pkg::CH_TWO);
			emit(b);
			emit_color(jpp_pkg::CH_FOUR);
		end else if (b == jpp_pkg::CH_COMMA) begin
			emit_color(jpp_pkg::CH_TWO);
			emit(b);
			emit_newline();
			emit_color(jpp_pkg::CH_FOUR);
		end else if (b == jpp_pkg::CH_COLON) begin
			emit_color(jpp_pkg::CH_TWO);
			emit(b);
			emit(jpp_pkg::CH_SPACE);
			emit_color(jpp_pkg::CH_FOUR);
		end else if (b == jpp_pkg::CH_QUOTE) begin
			in_string = 1'b1;
			esc_pending = 1'b0;
			emit_color(jpp_pkg::CH_ONE);
			emit(b);
		end else begin
			emit(b);
		end
		if (formatted_q.size() > first)
			formatted_q[formatted_q.size() - 1].last_of_run = 1'b1;
	endtask

	// text source
	always @(negedge clk) begin
		if (!text_ch.valid || text_taken) begin
			if (json_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				text_ch.valid <= 1'b1;
				text_ch.text_byte <= json_q[0].text_byte;
				text_ch.end_of_text <= json_q[0].end_of_text;
				void'(json_q.pop_front());
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
	end

	// output sink with random stalls and a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pretty_ch.ready <= 1'b0;
		end else if (hold_reqs != holds_done) begin
			hold_left <= HoldCycles;
			holds_done <= holds_done + 1;
			pretty_ch.ready <= 1'b0;
		end else begin
			pretty_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin
		text_taken <= text_ch.valid && text_ch.ready;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready)
				format_byte(text_ch.text_byte, text_ch.end_of_text);
			if (pretty_ch.valid && pretty_ch.ready) begin
				if (formatted_q.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", pretty_ch.out_byte));
				end else begin
					want = formatted_q.pop_front();
					if (pretty_ch.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte got %02h want %02h",
							pretty_ch.out_byte, want.out_byte));
					if (pretty_ch.last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last_of_run got %0b want %0b on byte %02h",
							pretty_ch.last_of_run, want.last_of_run, want.out_byte));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (pretty_ch.valid && pretty_ch.ready)
				|| (json_q.size() == 0 && !text_ch.valid && formatted_q.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles < StallLimit) begin
			stall_cycles <= stall_cycles + 1;
		end else begin
			$display("watchdog: no transaction in %0d cycles", StallLimit);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic put_text(input logic [7:0] b, input logic eot);
		json_q.push_back('{text_byte: b, end_of_text: eot});
		text_items++;
	endtask

	task automatic put_ws();
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(2))
				0: put_text(jpp_pkg::CH_SPACE, 1'b0);
				1: put_text(jpp_pkg::CH_TAB, 1'b0);
				default: put_text(jpp_pkg::CH_NL, 1'b0);
			endcase
		end
	endtask

	task automatic put_string();
		logic [7:0] c;
		put_text(jpp_pkg::CH_QUOTE, 1'b0);
		repeat ($urandom_range(4)) begin
			if ($urandom_range(5) == 0) begin
				put_text(jpp_pkg::CH_BSLASH, 1'b0);
				c = $urandom_range(3) == 0 ? jpp_pkg::CH_QUOTE : 8'($urandom_range(255));
				put_text(c, 1'b0);
			end else begin
				c = 8'($urandom_range(255));
				if (c == jpp_pkg::CH_QUOTE || c == jpp_pkg::CH_BSLASH)
					c = 8'h61;
				put_text(c, 1'b0);
			end
		end
		put_text(jpp_pkg::CH_QUOTE, 1'b0);
	endtask

	task automatic put_scalar();
		string lit;
		case ($urandom_range(2))
			0: put_string();
			1: begin
				if ($urandom_range(1))
					put_text(8'h2d, 1'b0);
				repeat ($urandom_range(1, 3))
					put_text(jpp_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
			end
			default: begin
				case ($urandom_range(2))
					0: lit = "true";
					1: lit = "false";
					default: lit = "null";
				endcase
				for (int i = 0; i < lit.len(); i++)
					put_text(lit[i], 1'b0);
			end
		endcase
	endtask

	task automatic put_open();
		bit obj;
		obj = 1'($urandom_range(1));
		put_text(obj ? jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACK, 1'b0);
		gen_obj_q.push_back(obj);
		gen_used_q.push_back(1'b0);
		put_ws();
	endtask

	// one well-formed document with random content, closed by end of text
	task automatic put_doc();
		int steps;
		int nest_max;
		nest_max = $urandom_range(1, 4);
		steps = $urandom_range(1, 8);
		put_ws();
		put_open();
		while (gen_obj_q.size() > 0) begin
			if (steps > 0 && $urandom_range(3) != 0) begin
				steps--;
				if (gen_used_q[gen_used_q.size() - 1]) begin
					put_text(jpp_pkg::CH_COMMA, 1'b0);
					put_ws();
				end
				gen_used_q[gen_used_q.size() - 1] = 1'b1;
				if (gen_obj_q[gen_obj_q.size() - 1]) begin
					put_string();
					put_ws();
					put_text(jpp_pkg::CH_COLON, 1'b0);
					put_ws();
				end
				if (gen_obj_q.size() < nest_max && $urandom_range(2) == 0) begin
					put_open();
				end else begin
					put_scalar();
					put_ws();
				end
			end else begin
				put_text(gen_obj_q[gen_obj_q.size() - 1] ? jpp_pkg::CH_RBRACE
					: jpp_pkg::CH_RBRACK, 1'b0);
				void'(gen_obj_q.pop_back());
				void'(gen_used_q.pop_back());
				put_ws();
			end
		end
		put_text(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic put_noise();
		case ($urandom_range(4))
			0: put_text(8'($urandom_range(255)), 1'b1);
			1: put_text($urandom_range(1) ? jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACK, 1'b0);
			2: put_text(jpp_pkg::CH_QUOTE, 1'b0);
			default: put_text(8'($urandom_range(255)), 1'b0);
		endcase
	endtask

	task automatic put_random(input int count);
		int target;
		target = text_items + count;
		while (text_items < target) begin
			if ($urandom_range(99) < 75)
				put_doc();
			else
				repeat ($urandom_range(1, 4)) put_noise();
		end
	endtask

	// nesting past the depth limit, optionally ending the text at full depth
	task automatic put_deep(input bit end_deep);
		repeat (MaxDepth + 2)
			put_text($urandom_range(1) ? jpp_pkg::CH_LBRACE : jpp_pkg::CH_LBRACK, 1'b0);
		if (!end_deep) begin
			put_text(jpp_pkg::CH_ONE, 1'b0);
			repeat (MaxDepth + 2)
				put_text($urandom_range(1) ? jpp_pkg::CH_RBRACE : jpp_pkg::CH_RBRACK, 1'b0);
		end
		put_text(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic set_color(input logic v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		color_on = v;
	endtask

	task automatic wait_drained();
		while (json_q.size() != 0 || text_ch.valid || formatted_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.end_of_text = 1'b0;
		pretty_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// colors off from reset: nesting, strings with escapes, low saturation
		put_text(jpp_pkg::CH_LBRACE, 1'b0);
		put_text(jpp_pkg::CH_QUOTE, 1'b0);
		put_text(jpp_pkg::CH_BSLASH, 1'b0);
		put_text(jpp_pkg::CH_QUOTE, 1'b0);
		put_text(jpp_pkg::CH_QUOTE, 1'b0);
		put_text(jpp_pkg::CH_COLON, 1'b0);
		put_text(jpp_pkg::CH_LBRACK, 1'b0);
		put_text(8'hff, 1'b0);
		put_text(jpp_pkg::CH_COMMA, 1'b0);
		put_text(jpp_pkg::CH_SPACE, 1'b0);
		put_text(jpp_pkg::CH_RBRACK, 1'b0);
		put_text(jpp_pkg::CH_RBRACE, 1'b0);
		put_text(jpp_pkg::CH_RBRACE, 1'b0);
		put_text(8'h00, 1'b1);
		wait_drained();

		// colors on: every punctuation kind, end of text inside a string
		set_color(1'b1);
		@(posedge clk);
		put_text(jpp_pkg::CH_QUOTE, 1'b0);
		put_text(jpp_pkg::CH_BSLASH, 1'b0);
		put_text(jpp_pkg::CH_BSLASH, 1'b0);
		put_text(8'h78, 1'b0);
		put_text(8'hff, 1'b1);
		put_text(jpp_pkg::CH_LBRACE, 1'b0);
		put_text(jpp_pkg::CH_COLON, 1'b0);
		put_text(jpp_pkg::CH_COMMA, 1'b0);
		put_text(jpp_pkg::CH_TAB, 1'b0);
		put_text(jpp_pkg::CH_NL, 1'b0);
		put_text(8'h00, 1'b0);
		put_text(jpp_pkg::CH_RBRACK, 1'b0);
		put_text(8'h00, 1'b1);
		wait_drained();

		// no idling on either side
		idle_pct = 0;
		set_color(1'b1);
		@(posedge clk);
		put_random(35);
		wait_drained();
		idle_pct = 34;

		// colors off, sink held off while the source keeps offering
		set_color(1'b0);
		@(posedge clk);
		hold_reqs++;
		put_random(40);
		wait_drained();

		// colors on, depth limit, then the source pauses until all output is out
		set_color(1'b1);
		@(posedge clk);
		put_deep(1'b0);
		put_deep(1'b1);
		wait_drained();
		put_random(35);
		wait_drained();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/jpp_pkg.sv
rtl/jpp_ifs.sv
rtl/jpp_decode.sv
rtl/json_pretty_printer.sv
rtl/jpp_checker.sv
dv/json_pretty_printer_tb.sv
